>>> rtl/pidt_pkg.sv
`default_nettype none

package pidt_pkg;

	localparam int SAMPLE_W     = 10;
	localparam int GAIN_W       = 16;
	localparam int TICK_W       = 16;
	localparam int DRIVE_W      = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int MPL_W        = 17;
	localparam int BOOTH_W      = 18;
	localparam int BOOTH_DIGITS = 9;
	localparam int BOOTH_CNT_W  = 4;
	localparam int FRAC_SHIFT   = 16;
	localparam int OUT_SHIFT    = 24;

	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd262;
	localparam logic [TICK_W-1:0] TICK_RATE_RST   = 16'd250;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET      = 3'd0,
		CFG_P_GAIN      = 3'd1,
		CFG_I_GAIN      = 3'd2,
		CFG_D_GAIN      = 3'd3,
		CFG_TICK_PERIOD = 3'd4,
		CFG_TICK_RATE   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic        [SAMPLE_W-1:0] target_value;
		logic signed [GAIN_W-1:0]   p_gain;
		logic signed [GAIN_W-1:0]   i_gain;
		logic signed [GAIN_W-1:0]   d_gain;
		logic        [TICK_W-1:0]   tick_period;
		logic        [TICK_W-1:0]   tick_rate;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic keep;
	} mul_cmd_t;

endpackage

`default_nettype wire

>>> rtl/pidt_cfg_regs.sv
`default_nettype none

module pidt_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pidt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output pidt_pkg::cfg_t                   cfg
);
	import pidt_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_value <= '0;
			cfg_q.p_gain       <= '0;
			cfg_q.i_gain       <= '0;
			cfg_q.d_gain       <= '0;
			cfg_q.tick_period  <= TICK_PERIOD_RST;
			cfg_q.tick_rate    <= TICK_RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TARGET:      cfg_q.target_value <= cfg_data[SAMPLE_W-1:0];
				CFG_P_GAIN:      cfg_q.p_gain       <= $signed(cfg_data);
				CFG_I_GAIN:      cfg_q.i_gain       <= $signed(cfg_data);
				CFG_D_GAIN:      cfg_q.d_gain       <= $signed(cfg_data);
				CFG_TICK_PERIOD: cfg_q.tick_period  <= cfg_data;
				CFG_TICK_RATE:   cfg_q.tick_rate    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/pidt_booth_mul.sv
`default_nettype none

module pidt_booth_mul #(
	parameter int ACC_W = 63
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pidt_pkg::mul_cmd_t                 cmd,
	input  logic signed [ACC_W-1:0]            mcand,
	input  logic signed [pidt_pkg::MPL_W-1:0]  mplier,
	output logic                               busy,
	output logic signed [ACC_W-1:0]            acc
);
	import pidt_pkg::*;

	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   mcand_q;
	logic signed [BOOTH_W-1:0] m_q;
	logic                      mprev_q;
	logic [BOOTH_CNT_W-1:0]    cnt_q;
	logic signed [ACC_W-1:0]   pp;

	assign busy = (cnt_q != '0);
	assign acc  = acc_q;

	// radix-4 Booth digit from two multiplier bits and the last bit shifted out
	always_comb begin
		case ({m_q[1:0], mprev_q}) inside
			3'b001, 3'b010: pp = mcand_q;
			3'b011:         pp = mcand_q <<< 1;
			3'b100:         pp = -(mcand_q <<< 1);
			3'b101, 3'b110: pp = -mcand_q;
			default:        pp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= BOOTH_CNT_W'(BOOTH_DIGITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q   <= cmd.keep ? acc_q : '0;
			mcand_q <= mcand;
			m_q     <= BOOTH_W'(mplier);
			mprev_q <= 1'b0;
		end else if (busy) begin
			acc_q   <= acc_q + pp;
			mcand_q <= mcand_q <<< 2;
			m_q     <= m_q >>> 2;
			mprev_q <= m_q[1];
		end
	end

endmodule

`default_nettype wire

>>> rtl/pid_trapezoid_integral_controller.sv
// A sample runs through the shared radix-4 Booth multiplier for up to five products
// (increment, rate difference, I, P, D); the D product is skipped when the previous error is
// zero, and a clear or a failed sensor read skips the multiplier. One transaction is in work at
// a time, so a new one is taken only after the last result is out; a result held back by
// out_ready stalls the input for as long as it is held.
// Reset clears the error, integral and drive state and loads the register defaults.
`default_nettype none

module pid_trapezoid_integral_controller #(
	parameter int SAMPLE_BITS = 10,
	parameter int ACC_BITS    = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  mode,
	input  logic [pidt_pkg::SAMPLE_W-1:0]         sample_value,
	input  logic                                  sensor_ok,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pidt_pkg::DRIVE_W-1:0]   drive_value,
	output logic                                  status,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pidt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pidt_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import pidt_pkg::*;

	localparam int ERR_W  = SAMPLE_BITS + 2;
	localparam int DPRE_W = SAMPLE_BITS + 19;
	localparam int SUM_W  = (SAMPLE_BITS + 53 > ACC_BITS + 18) ? SAMPLE_BITS + 53 : ACC_BITS + 18;
	localparam int Q_W    = SUM_W - OUT_SHIFT;

	localparam logic [SAMPLE_W-1:0] SMASK = (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
		: SAMPLE_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [SUM_W-1:0] RND = SUM_W'({OUT_SHIFT{1'b1}});
	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic signed [DRIVE_W-1:0]  DRV_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [DRIVE_W-1:0]  DRV_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_INC   = 9'b000000010,
		ST_INTEG = 9'b000000100,
		ST_DPRE  = 9'b000001000,
		ST_ITERM = 9'b000010000,
		ST_PTERM = 9'b000100000,
		ST_DTERM = 9'b001000000,
		ST_DRIVE = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	cfg_t                      cfg;
	state_t                    state_q;
	logic                      issued_q;
	logic signed [ERR_W-1:0]   e_q;
	logic signed [ERR_W-1:0]   last_error_q;
	logic signed [ACC_BITS-1:0] integral_q;
	logic signed [DRIVE_W-1:0] last_drive_q;
	logic                      fail_q;
	logic signed [DPRE_W-1:0]  dpre_q;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      status_q;

	logic                      accept;
	logic                      out_free;
	logic signed [ERR_W-1:0]   e_new;
	logic signed [ERR_W-1:0]   err_sum;
	logic signed [ERR_W-1:0]   err_diff;
	logic                      is_mul;
	logic                      keep;
	logic signed [SUM_W-1:0]   mcand;
	logic signed [MPL_W-1:0]   mplier;
	mul_cmd_t                  mul_cmd;
	logic                      mul_busy;
	logic                      mul_done;
	logic signed [SUM_W-1:0]   mul_acc;

	logic signed [SUM_W-1:0]   isum;
	logic [SUM_W-ACC_BITS:0]   isum_hi;
	logic signed [ACC_BITS-1:0] isat;
	logic signed [SUM_W-1:0]   rsum;
	logic signed [Q_W-1:0]     q;
	logic [Q_W-DRIVE_W:0]      q_hi;
	logic signed [DRIVE_W-1:0] dsat;

	pidt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidt_booth_mul #(
		.ACC_W (SUM_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.mcand  (mcand),
		.mplier (mplier),
		.busy   (mul_busy),
		.acc    (mul_acc)
	);

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;
	assign status      = status_q;
	assign out_free    = !out_valid_q || out_ready;

	assign e_new = $signed(ERR_W'(sample_value & SMASK))
		- $signed(ERR_W'(cfg.target_value & SMASK));
	assign err_sum  = last_error_q + e_q;
	assign err_diff = e_q - last_error_q;

	always_comb begin
		is_mul = 1'b0;
		keep   = 1'b0;
		mcand  = '0;
		mplier = '0;
		unique case (state_q)
			ST_INC: begin
				is_mul = 1'b1;
				mcand  = SUM_W'(err_sum);
				mplier = $signed({1'b0, cfg.tick_period});
			end
			ST_DPRE: begin
				is_mul = 1'b1;
				mcand  = SUM_W'(err_diff);
				mplier = $signed({1'b0, cfg.tick_rate});
			end
			ST_ITERM: begin
				is_mul = 1'b1;
				mcand  = SUM_W'(integral_q);
				mplier = MPL_W'(cfg.i_gain);
			end
			ST_PTERM: begin
				is_mul = 1'b1;
				keep   = 1'b1;
				mcand  = SUM_W'(e_q) <<< FRAC_SHIFT;
				mplier = MPL_W'(cfg.p_gain);
			end
			ST_DTERM: begin
				is_mul = 1'b1;
				keep   = 1'b1;
				mcand  = SUM_W'(dpre_q) <<< FRAC_SHIFT;
				mplier = MPL_W'(cfg.d_gain);
			end
			default: ;
		endcase
	end

	assign mul_cmd.start = is_mul && !issued_q && !mul_busy;
	assign mul_cmd.keep  = keep;
	assign mul_done      = is_mul && issued_q && !mul_busy;

	// trapezoid increment halved toward minus infinity, then saturate
	always_comb begin
		isum    = SUM_W'(integral_q) + (mul_acc >>> 1);
		isum_hi = isum[SUM_W-1:ACC_BITS-1];
		if ((&isum_hi) || !(|isum_hi)) begin
			isat = isum[ACC_BITS-1:0];
		end else begin
			isat = isum[SUM_W-1] ? ACC_MIN : ACC_MAX;
		end
	end

	// truncate toward zero to an integer, then saturate
	always_comb begin
		rsum = mul_acc + (mul_acc[SUM_W-1] ? $signed(RND) : $signed(SUM_W'(0)));
		q    = rsum[SUM_W-1:OUT_SHIFT];
		q_hi = q[Q_W-1:DRIVE_W-1];
		if ((&q_hi) || !(|q_hi)) begin
			dsat = q[DRIVE_W-1:0];
		end else begin
			dsat = q[Q_W-1] ? DRV_MIN : DRV_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issued_q     <= 1'b0;
			last_error_q <= '0;
			integral_q   <= '0;
			last_drive_q <= '0;
			fail_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (mul_cmd.start) begin
				issued_q <= 1'b1;
			end else if (mul_done) begin
				issued_q <= 1'b0;
			end

			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode) begin
							last_error_q <= '0;
							integral_q   <= '0;
							last_drive_q <= '0;
							fail_q       <= 1'b0;
							state_q      <= ST_OUT;
						end else if (!sensor_ok) begin
							fail_q  <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							fail_q  <= 1'b0;
							state_q <= ST_INC;
						end
					end
				end
				ST_INC: begin
					if (mul_done) begin
						state_q <= ST_INTEG;
					end
				end
				ST_INTEG: begin
					integral_q <= isat;
					state_q    <= ST_DPRE;
				end
				ST_DPRE: begin
					if (mul_done) begin
						state_q <= ST_ITERM;
					end
				end
				ST_ITERM: begin
					if (mul_done) begin
						state_q <= ST_PTERM;
					end
				end
				ST_PTERM: begin
					if (mul_done) begin
						state_q <= (last_error_q != '0) ? ST_DTERM : ST_DRIVE;
					end
				end
				ST_DTERM: begin
					if (mul_done) begin
						state_q <= ST_DRIVE;
					end
				end
				ST_DRIVE: begin
					last_drive_q <= dsat;
					last_error_q <= e_q;
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q <= e_new;
		end
		if (state_q == ST_DPRE && mul_done) begin
			dpre_q <= DPRE_W'(mul_acc);
		end
		if (state_q == ST_OUT && out_free) begin
			drive_q  <= last_drive_q;
			status_q <= fail_q;
		end
	end

endmodule

`default_nettype wire
